### hdl/bfis_pkg.sv
`default_nettype none

package bfis_pkg;

  // Fixed field widths of the command and result ports
  localparam int unsigned CH_W       = 8;
  localparam int unsigned LOAD_W     = 7;
  localparam int unsigned QUERY_W    = 10;
  localparam int unsigned SRC_REG_W  = 8;
  localparam int unsigned DST_REG_W  = 11;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned RGBA_BYTES = 4;
  localparam int unsigned PIX_MAX    = 255;

  // Configuration register map, one word apart
  typedef enum logic [1:0] {
    REG_SRC_W,
    REG_SRC_H,
    REG_DST_W,
    REG_DST_H
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_CLIP,
    ST_RD,
    ST_CH
  } state_e;

  // Jobs handed to the shared divider, in the order they run
  typedef enum logic [2:0] {
    DIV_X0,
    DIV_X1,
    DIV_Y0,
    DIV_Y1,
    DIV_RED,
    DIV_GREEN,
    DIV_BLUE
  } div_sel_e;

  // Color channel under accumulation
  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_e;

  // Composite one channel over black: floor(c*a/255), exact for c,a <= 255
  function automatic logic [CH_W-1:0] premultiply(input logic [CH_W-1:0] c,
                                                  input logic [CH_W-1:0] a);
    logic [2*CH_W-1:0] p;
    logic [2*CH_W:0]   s;
    p = c * a;
    s = (2*CH_W+1)'(p) + (2*CH_W+1)'(p[2*CH_W-1:CH_W]) + (2*CH_W+1)'(1);
    return s[2*CH_W-1:CH_W];
  endfunction

endpackage

`default_nettype wire

### hdl/bfis_div.sv
`default_nettype none

module bfis_div #(
  parameter int unsigned NUM_W = 22,
  parameter int unsigned DEN_W = 15
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   rem_sh;
  logic             q_bit;
  logic [DEN_W:0]   rem_sub;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    q_bit   = (rem_sh >= {1'b0, den_q});
    rem_sub = q_bit ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  // Control: count the steps, pulse done after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out the top while quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], q_bit};
      rem_q <= rem_sub[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

### hdl/bfis_store.sv
`default_nettype none

module bfis_store #(
  parameter int unsigned AW = 14,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [DW-1:0] rd_data_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  // Write one pixel per load transaction
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hdl/box_filter_image_scaler.sv
`default_nettype none

// Box-filter (area average) image scaler.
// Command channel: a transaction is taken when start is high and busy is low.
//   cmd_i = 0 writes one RGBA pixel into the source store at (load_col_i,
//   load_row_i) and gives no result. A pixel outside the store is dropped.
//   cmd_i = 1 asks for destination pixel (query_col_i, query_row_i). A
//   coordinate outside the target size answers with zeros and coord_error_o
//   in the next cycle. Otherwise the block holds busy high and runs seven
//   divisions on one shared restoring divider (four for the box edges, three
//   for the channel averages) plus a walk over the source box. Each source
//   pixel takes one store read and one multiply per channel.
// Result channel: done_o is high for exactly one cycle with the result on
//   out_*_o and coord_error_o; the receiver cannot stall it.
// Configuration: APB, registers source_width, source_height, target_width,
//   target_height at byte offsets 0, 4, 8, 12; write only while idle.
// Reset: clears the sequencer and sets sizes to 128, 128, 64, 64. The pixel
//   store is not cleared; read only pixels that were loaded.
module box_filter_image_scaler
  import bfis_pkg::*;
#(
  parameter int unsigned MAX_SRC_WIDTH  = 128,
  parameter int unsigned MAX_SRC_HEIGHT = 128,
  parameter int unsigned MAX_DST_DIM    = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cmd_i,
  input  wire logic [LOAD_W-1:0]  load_col_i,
  input  wire logic [LOAD_W-1:0]  load_row_i,
  input  wire logic [CH_W-1:0]    in_red_i,
  input  wire logic [CH_W-1:0]    in_green_i,
  input  wire logic [CH_W-1:0]    in_blue_i,
  input  wire logic [CH_W-1:0]    in_alpha_i,
  input  wire logic [QUERY_W-1:0] query_col_i,
  input  wire logic [QUERY_W-1:0] query_row_i,
  // result channel
  output logic                    done_o,
  output logic      [CH_W-1:0]    out_red_o,
  output logic      [CH_W-1:0]    out_green_o,
  output logic      [CH_W-1:0]    out_blue_o,
  output logic                    coord_error_o,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int unsigned CW   = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
  localparam int unsigned RH   = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
  localparam int unsigned SWW  = $clog2(MAX_SRC_WIDTH + 1);
  localparam int unsigned SHW  = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int unsigned SRCW = (SWW > SHW) ? SWW : SHW;
  localparam int unsigned TWW  = $clog2(MAX_DST_DIM + 1);
  localparam int unsigned MULW = QUERY_W + 1 + SRCW;
  localparam int unsigned NPIX = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned NW   = $clog2(NPIX + 1);
  localparam int unsigned SUMW = $clog2(PIX_MAX * NPIX + 1);
  localparam int unsigned DIVW = (MULW > SUMW) ? MULW : SUMW;
  localparam int unsigned DENW = (TWW > NW) ? TWW : NW;
  localparam int unsigned PXW  = CH_W * RGBA_BYTES;

  // Configuration registers
  logic [SRC_REG_W-1:0] src_w_q, src_h_q;
  logic [DST_REG_W-1:0] dst_w_q, dst_h_q;
  logic                 cfg_wr;

  // Sequencer and datapath registers
  state_e               state_q, state_d;
  div_sel_e             sel_q;
  chan_e                ch_q;
  logic                 done_q;
  logic                 err_q;
  logic [QUERY_W-1:0]   qx_q, qy_q;
  logic [SRCW-1:0]      x0_q, x1_q, y0_q, y1_q, xx_q, yy_q;
  logic [SUMW-1:0]      sum_r_q, sum_g_q, sum_b_q;
  logic [NW-1:0]        n_q;
  logic [CH_W-1:0]      red_q, green_q, blue_q;

  // Combinational helpers
  logic [SRCW-1:0]      sw_eff, sh_eff;
  logic [TWW-1:0]       tw_eff, th_eff;
  logic                 accept;
  logic                 q_out;
  logic                 load_ok;
  logic [QUERY_W:0]     mul_a;
  logic [SRCW-1:0]      mul_b;
  logic [MULW-1:0]      mul_p;
  logic [DIVW-1:0]      div_num;
  logic [DENW-1:0]      div_den;
  logic                 div_start;
  logic                 div_done;
  logic [DIVW-1:0]      div_quot;
  logic [SRCW-1:0]      x1_clip, y1_clip, x1_lo, y1_lo;
  logic [PXW-1:0]       rd_data;
  logic [CH_W-1:0]      chan_val;
  logic [CH_W-1:0]      chan_pm;
  logic                 last_x, last_y;

  // APB register writes
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SRC_REG_W'(128);
      src_h_q <= SRC_REG_W'(128);
      dst_w_q <= DST_REG_W'(64);
      dst_h_q <= DST_REG_W'(64);
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_SRC_W: src_w_q <= pwdata[SRC_REG_W-1:0];
        REG_SRC_H: src_h_q <= pwdata[SRC_REG_W-1:0];
        REG_DST_W: dst_w_q <= pwdata[DST_REG_W-1:0];
        REG_DST_H: dst_h_q <= pwdata[DST_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // APB register reads
  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_SRC_W: prdata = PDATA_W'(src_w_q);
      REG_SRC_H: prdata = PDATA_W'(src_h_q);
      REG_DST_W: prdata = PDATA_W'(dst_w_q);
      REG_DST_H: prdata = PDATA_W'(dst_h_q);
      default:   prdata = '0;
    endcase
  end

  // Saturate the sizes in use
  always_comb begin
    if (src_w_q == '0) sw_eff = SRCW'(1);
    else if (32'(src_w_q) > MAX_SRC_WIDTH) sw_eff = SRCW'(MAX_SRC_WIDTH);
    else sw_eff = SRCW'(src_w_q);

    if (src_h_q == '0) sh_eff = SRCW'(1);
    else if (32'(src_h_q) > MAX_SRC_HEIGHT) sh_eff = SRCW'(MAX_SRC_HEIGHT);
    else sh_eff = SRCW'(src_h_q);

    if (32'(dst_w_q) > MAX_DST_DIM) tw_eff = TWW'(MAX_DST_DIM);
    else tw_eff = TWW'(dst_w_q);

    if (32'(dst_h_q) > MAX_DST_DIM) th_eff = TWW'(MAX_DST_DIM);
    else th_eff = TWW'(dst_h_q);
  end

  // Command decode
  assign accept  = start && !busy;
  assign q_out   = (32'(query_col_i) >= 32'(tw_eff)) || (32'(query_row_i) >= 32'(th_eff));
  assign load_ok = (32'(load_col_i) < MAX_SRC_WIDTH) && (32'(load_row_i) < MAX_SRC_HEIGHT);

  // Pixel store
  bfis_store #(
    .AW(CW + RH),
    .DW(PXW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (accept && !cmd_i && load_ok),
    .wr_addr_i({RH'(load_row_i), CW'(load_col_i)}),
    .wr_data_i({in_alpha_i, in_blue_i, in_green_i, in_red_i}),
    .rd_addr_i({RH'(yy_q), CW'(xx_q)}),
    .rd_data_o(rd_data)
  );

  // Select dividend and divisor for the current divider job
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_den = DENW'(tw_eff);
    case (sel_q)
      DIV_X0: begin
        mul_a = (QUERY_W+1)'(qx_q);
        mul_b = sw_eff;
      end
      DIV_X1: begin
        mul_a = (QUERY_W+1)'(qx_q) + (QUERY_W+1)'(1);
        mul_b = sw_eff;
      end
      DIV_Y0: begin
        mul_a   = (QUERY_W+1)'(qy_q);
        mul_b   = sh_eff;
        div_den = DENW'(th_eff);
      end
      DIV_Y1: begin
        mul_a   = (QUERY_W+1)'(qy_q) + (QUERY_W+1)'(1);
        mul_b   = sh_eff;
        div_den = DENW'(th_eff);
      end
      default: div_den = DENW'(n_q);
    endcase
    mul_p = MULW'(mul_a) * MULW'(mul_b);
    case (sel_q)
      DIV_RED:   div_num = DIVW'(sum_r_q);
      DIV_GREEN: div_num = DIVW'(sum_g_q);
      DIV_BLUE:  div_num = DIVW'(sum_b_q);
      default:   div_num = DIVW'(mul_p);
    endcase
  end

  assign div_start = (state_q == ST_PREP);

  bfis_div #(
    .NUM_W(DIVW),
    .DEN_W(DENW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Clip box ends: at least one pixel, never past the source
  always_comb begin
    x1_lo   = (x1_q <= x0_q) ? (x0_q + SRCW'(1)) : x1_q;
    y1_lo   = (y1_q <= y0_q) ? (y0_q + SRCW'(1)) : y1_q;
    x1_clip = (x1_lo > sw_eff) ? sw_eff : x1_lo;
    y1_clip = (y1_lo > sh_eff) ? sh_eff : y1_lo;
  end

  // Premultiply the channel under work
  always_comb begin
    case (ch_q)
      CH_RED:   chan_val = rd_data[CH_W-1:0];
      CH_GREEN: chan_val = rd_data[2*CH_W-1:CH_W];
      CH_BLUE:  chan_val = rd_data[3*CH_W-1:2*CH_W];
      default:  chan_val = '0;
    endcase
    chan_pm = premultiply(chan_val, rd_data[4*CH_W-1:3*CH_W]);
  end

  assign last_x = (xx_q + SRCW'(1)) == x1_q;
  assign last_y = (yy_q + SRCW'(1)) == y1_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i && !q_out) state_d = ST_PREP;
      end
      ST_PREP: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          if (sel_q == DIV_Y1) state_d = ST_CLIP;
          else if (sel_q == DIV_BLUE) state_d = ST_IDLE;
          else state_d = ST_PREP;
        end
      end
      ST_CLIP: state_d = ST_RD;
      ST_RD:   state_d = ST_CH;
      ST_CH: begin
        if (ch_q == CH_BLUE) begin
          state_d = (last_x && last_y) ? ST_PREP : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= DIV_X0;
      ch_q    <= CH_RED;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept && cmd_i) begin
            sel_q  <= DIV_X0;
            done_q <= q_out;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            sel_q <= div_sel_e'(sel_q + 3'd1);
            if (sel_q == DIV_BLUE) done_q <= 1'b1;
          end
        end
        ST_CLIP: ch_q <= CH_RED;
        ST_CH: begin
          case (ch_q)
            CH_RED:   ch_q <= CH_GREEN;
            CH_GREEN: ch_q <= CH_BLUE;
            default:  ch_q <= CH_RED;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i) begin
          qx_q  <= query_col_i;
          qy_q  <= query_row_i;
          err_q <= q_out;
          if (q_out) begin
            red_q   <= '0;
            green_q <= '0;
            blue_q  <= '0;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          case (sel_q)
            DIV_X0:    x0_q    <= SRCW'(div_quot);
            DIV_X1:    x1_q    <= SRCW'(div_quot);
            DIV_Y0:    y0_q    <= SRCW'(div_quot);
            DIV_Y1:    y1_q    <= SRCW'(div_quot);
            DIV_RED:   red_q   <= CH_W'(div_quot);
            DIV_GREEN: green_q <= CH_W'(div_quot);
            DIV_BLUE:  blue_q  <= CH_W'(div_quot);
            default: ;
          endcase
        end
      end
      ST_CLIP: begin
        x1_q    <= x1_clip;
        y1_q    <= y1_clip;
        xx_q    <= x0_q;
        yy_q    <= y0_q;
        sum_r_q <= '0;
        sum_g_q <= '0;
        sum_b_q <= '0;
        n_q     <= '0;
      end
      ST_CH: begin
        case (ch_q)
          CH_RED:   sum_r_q <= sum_r_q + SUMW'(chan_pm);
          CH_GREEN: sum_g_q <= sum_g_q + SUMW'(chan_pm);
          default:  sum_b_q <= sum_b_q + SUMW'(chan_pm);
        endcase
        // Advance to the next source pixel after the last channel
        if (ch_q == CH_BLUE) begin
          n_q <= n_q + NW'(1);
          if (last_x) begin
            xx_q <= x0_q;
            yy_q <= yy_q + SRCW'(1);
          end else begin
            xx_q <= xx_q + SRCW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign done_o        = done_q;
  assign out_red_o     = red_q;
  assign out_green_o   = green_q;
  assign out_blue_o    = blue_q;
  assign coord_error_o = err_q;

  // A result never appears while a compute is still running
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // An error result carries zero color
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && coord_error_o) |-> (out_red_o == '0 && out_green_o == '0 && out_blue_o == '0))
    else $error("error result with nonzero color");

  // A load transaction produces no result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !cmd_i) |=> !done_o)
    else $error("load produced a result");

endmodule

`default_nettype wire

### bench/tb_box_filter_image_scaler.sv
`default_nettype none

module tb_box_filter_image_scaler;
  timeunit 1ns;
  timeprecision 1ps;

  import bfis_pkg::*;

  localparam int unsigned SRC_MAX          = 128;
  localparam int unsigned DST_MAX          = 1024;
  localparam int unsigned STORE_DEPTH      = SRC_MAX * SRC_MAX;
  localparam int unsigned N_PHASES         = 12;
  localparam int unsigned RANDOM_PER_PHASE = 116;
  localparam int unsigned TAIL_CYCLES      = 400;
  localparam int unsigned REPORT_LIMIT     = 10;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_COMPUTE = 1'b1
  } cmd_e;

  // Idling patterns; the result side cannot stall, so its pattern idles nothing
  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [LOAD_W-1:0]  col;
    logic [LOAD_W-1:0]  row;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic [CH_W-1:0]    alpha;
    logic [QUERY_W-1:0] qx;
    logic [QUERY_W-1:0] qy;
  } scaler_cmd_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            coord_error;
  } pixel_result_t;

  typedef struct {
    scaler_cmd_t   it;
    bit            typed;
    pixel_result_t want;
  } directed_row_t;

  typedef struct {
    int unsigned sw;
    int unsigned sh;
    int unsigned tw;
    int unsigned th;
    idle_e       mode;
  } phase_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               cmd_i;
  logic [LOAD_W-1:0]  load_col_i;
  logic [LOAD_W-1:0]  load_row_i;
  logic [CH_W-1:0]    in_red_i;
  logic [CH_W-1:0]    in_green_i;
  logic [CH_W-1:0]    in_blue_i;
  logic [CH_W-1:0]    in_alpha_i;
  logic [QUERY_W-1:0] query_col_i;
  logic [QUERY_W-1:0] query_row_i;
  logic               done_o;
  logic [CH_W-1:0]    out_red_o;
  logic [CH_W-1:0]    out_green_o;
  logic [CH_W-1:0]    out_blue_o;
  logic               coord_error_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Shadow of the block: source store, which entries were loaded, size registers
  logic [31:0]        src_pixels [STORE_DEPTH];
  bit                 src_loaded [STORE_DEPTH];
  logic [SRC_REG_W-1:0] src_w_q;
  logic [SRC_REG_W-1:0] src_h_q;
  logic [DST_REG_W-1:0] dst_w_q;
  logic [DST_REG_W-1:0] dst_h_q;

  pixel_result_t      pending_pixels [$];
  int unsigned        mismatches;
  directed_row_t      directed [$];
  phase_t             phases [N_PHASES];

  box_filter_image_scaler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .load_col_i    (load_col_i),
    .load_row_i    (load_row_i),
    .in_red_i      (in_red_i),
    .in_green_i    (in_green_i),
    .in_blue_i     (in_blue_i),
    .in_alpha_i    (in_alpha_i),
    .query_col_i   (query_col_i),
    .query_row_i   (query_row_i),
    .done_o        (done_o),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .coord_error_o (coord_error_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sizes in use: source saturated to 1..max, target saturated to max
  function automatic int unsigned eff_src(int unsigned v);
    if (v < 1) return 1;
    if (v > SRC_MAX) return SRC_MAX;
    return v;
  endfunction

  function automatic int unsigned eff_dst(int unsigned v);
    return (v > DST_MAX) ? DST_MAX : v;
  endfunction

  // Average the premultiplied source box behind one destination pixel
  function automatic pixel_result_t area_average(logic [QUERY_W-1:0] qx,
                                                 logic [QUERY_W-1:0] qy);
    int unsigned   sw, sh, tw, th, cx, cy;
    int unsigned   x0, x1, y0, y1, n, sr, sg, sb, a;
    logic [31:0]   px;
    pixel_result_t res;
    sw  = eff_src(src_w_q);
    sh  = eff_src(src_h_q);
    tw  = eff_dst(dst_w_q);
    th  = eff_dst(dst_h_q);
    cx  = qx;
    cy  = qy;
    res = '0;
    if (cx >= tw || cy >= th) begin
      res.coord_error = 1'b1;
      return res;
    end
    x0 = cx * sw / tw;
    x1 = (cx + 1) * sw / tw;
    if (x1 <= x0) x1 = x0 + 1;
    if (x1 > sw) x1 = sw;
    y0 = cy * sh / th;
    y1 = (cy + 1) * sh / th;
    if (y1 <= y0) y1 = y0 + 1;
    if (y1 > sh) y1 = sh;
    sr = 0;
    sg = 0;
    sb = 0;
    n  = 0;
    for (int unsigned yy = y0; yy < y1; yy++) begin
      for (int unsigned xx = x0; xx < x1; xx++) begin
        px = src_pixels[yy * SRC_MAX + xx];
        a  = px[31:24];
        sr += px[7:0] * a / 255;
        sg += px[15:8] * a / 255;
        sb += px[23:16] * a / 255;
        n++;
      end
    end
    res.red   = CH_W'(sr / n);
    res.green = CH_W'(sg / n);
    res.blue  = CH_W'(sb / n);
    return res;
  endfunction

  // Random content in every field; alpha leans toward its extremes
  function automatic scaler_cmd_t random_fields();
    scaler_cmd_t it;
    it.cmd   = cmd_e'($urandom_range(0, 1));
    it.col   = LOAD_W'($urandom);
    it.row   = LOAD_W'($urandom);
    it.red   = CH_W'($urandom);
    it.green = CH_W'($urandom);
    it.blue  = CH_W'($urandom);
    it.qx    = QUERY_W'($urandom);
    it.qy    = QUERY_W'($urandom);
    case ($urandom_range(0, 3))
      0:       it.alpha = '0;
      1:       it.alpha = '1;
      default: it.alpha = CH_W'($urandom);
    endcase
    return it;
  endfunction

  function automatic directed_row_t load_row(int unsigned col, int unsigned row,
                                             logic [31:0] rgba);
    directed_row_t d;
    d.it       = random_fields();
    d.it.cmd   = CMD_LOAD;
    d.it.col   = LOAD_W'(col);
    d.it.row   = LOAD_W'(row);
    d.it.red   = rgba[31:24];
    d.it.green = rgba[23:16];
    d.it.blue  = rgba[15:8];
    d.it.alpha = rgba[7:0];
    d.typed    = 1'b0;
    d.want     = '0;
    return d;
  endfunction

  function automatic directed_row_t query_row(int unsigned qx, int unsigned qy,
                                              bit typed, pixel_result_t want);
    directed_row_t d;
    d.it     = random_fields();
    d.it.cmd = CMD_COMPUTE;
    d.it.qx  = QUERY_W'(qx);
    d.it.qy  = QUERY_W'(qy);
    d.typed  = typed;
    d.want   = want;
    return d;
  endfunction

  function automatic int unsigned sender_gap(idle_e mode);
    case (mode)
      IDLE_SENDER: return ($urandom_range(0, 99) < 68) ? $urandom_range(1, 5) : 0;
      IDLE_BOTH:   return ($urandom_range(0, 99) < 24) ? $urandom_range(1, 5) : 0;
      default:     return 0;
    endcase
  endfunction

  // Drive one transaction, hold it until taken, then update the shadow
  task automatic send_item(input scaler_cmd_t it, input bit typed,
                           input pixel_result_t want, input int unsigned gap);
    start       <= 1'b1;
    cmd_i       <= it.cmd;
    load_col_i  <= it.col;
    load_row_i  <= it.row;
    in_red_i    <= it.red;
    in_green_i  <= it.green;
    in_blue_i   <= it.blue;
    in_alpha_i  <= it.alpha;
    query_col_i <= it.qx;
    query_row_i <= it.qy;
    do @(posedge clk_i); while (busy);
    if (it.cmd == CMD_LOAD) begin
      src_pixels[it.row * SRC_MAX + it.col] = {it.alpha, it.blue, it.green, it.red};
      src_loaded[it.row * SRC_MAX + it.col] = 1'b1;
    end else begin
      pending_pixels.push_back(typed ? want : area_average(it.qx, it.qy));
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every result is in and the block is idle
  task automatic settle();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SRC_W: src_w_q = SRC_REG_W'(value);
      REG_SRC_H: src_h_q = SRC_REG_W'(value);
      REG_DST_W: dst_w_q = DST_REG_W'(value);
      REG_DST_H: dst_h_q = DST_REG_W'(value);
      default:   ;
    endcase
  endtask

  // Run one phase: set sizes, load the source area still missing, then mix
  task automatic run_phase(input phase_t ph);
    int unsigned   sw_e, sh_e, tw_e, th_e;
    scaler_cmd_t   it;
    pixel_result_t none;
    none = '0;
    write_reg(REG_SRC_W, ph.sw);
    write_reg(REG_SRC_H, ph.sh);
    write_reg(REG_DST_W, ph.tw);
    write_reg(REG_DST_H, ph.th);
    sw_e = eff_src(src_w_q);
    sh_e = eff_src(src_h_q);
    tw_e = eff_dst(dst_w_q);
    th_e = eff_dst(dst_h_q);
    for (int unsigned r = 0; r < sh_e; r++) begin
      for (int unsigned c = 0; c < sw_e; c++) begin
        if (!src_loaded[r * SRC_MAX + c]) begin
          it     = random_fields();
          it.cmd = CMD_LOAD;
          it.col = LOAD_W'(c);
          it.row = LOAD_W'(r);
          send_item(it, 1'b0, none, sender_gap(ph.mode));
        end
      end
    end
    for (int unsigned i = 0; i < RANDOM_PER_PHASE; i++) begin
      // hold off halfway until the pipeline is empty
      if (i == RANDOM_PER_PHASE / 2) settle();
      it = random_fields();
      if ($urandom_range(0, 99) < 70) begin
        it.cmd = CMD_COMPUTE;
        if ($urandom_range(0, 99) < 85) begin
          if (tw_e > 0) it.qx = QUERY_W'($urandom_range(0, tw_e - 1));
          if (th_e > 0) it.qy = QUERY_W'($urandom_range(0, th_e - 1));
        end
      end else begin
        it.cmd = CMD_LOAD;
        if ($urandom_range(0, 1) == 1) begin
          it.col = LOAD_W'($urandom_range(0, sw_e - 1));
          it.row = LOAD_W'($urandom_range(0, sh_e - 1));
        end
      end
      send_item(it, 1'b0, none, sender_gap(ph.mode));
    end
    settle();
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin : result_check
    pixel_result_t got, want;
    if (rst_ni && done_o) begin
      got = {out_red_o, out_green_o, out_blue_o, coord_error_o};
      if (pending_pixels.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result r=%0d g=%0d b=%0d err=%0d",
                   got.red, got.green, got.blue, got.coord_error);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (got != want) begin
          if (mismatches < REPORT_LIMIT)
            $display("mismatch: exp r=%0d g=%0d b=%0d err=%0d, got r=%0d g=%0d b=%0d err=%0d",
                     want.red, want.green, want.blue, want.coord_error,
                     got.red, got.green, got.blue, got.coord_error);
          mismatches++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    pixel_result_t white, outside, none;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd_i       = CMD_LOAD;
    load_col_i  = '0;
    load_row_i  = '0;
    in_red_i    = '0;
    in_green_i  = '0;
    in_blue_i   = '0;
    in_alpha_i  = '0;
    query_col_i = '0;
    query_row_i = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    mismatches  = 0;
    src_w_q     = SRC_REG_W'(128);
    src_h_q     = SRC_REG_W'(128);
    dst_w_q     = DST_REG_W'(64);
    dst_h_q     = DST_REG_W'(64);
    none        = '0;
    white       = '{red: '1, green: '1, blue: '1, coord_error: 1'b0};
    outside     = '{red: '0, green: '0, blue: '0, coord_error: 1'b1};
    foreach (src_loaded[k]) src_loaded[k] = 1'b0;

    // Directed table, reset sizes: 128x128 source to 64x64 target
    directed.push_back(load_row(0, 0, 32'hffffffff));
    directed.push_back(load_row(1, 0, 32'hffffffff));
    directed.push_back(load_row(0, 1, 32'hffffffff));
    directed.push_back(load_row(1, 1, 32'hffffffff));
    directed.push_back(query_row(0, 0, 1'b1, white));
    directed.push_back(query_row(64, 0, 1'b1, outside));
    directed.push_back(query_row(0, 64, 1'b1, outside));
    directed.push_back(query_row(1023, 1023, 1'b1, outside));
    // a transparent pixel adds black to the average
    directed.push_back(load_row(1, 1, 32'hff008000));
    directed.push_back(query_row(0, 0, 1'b0, none));
    // far corner, mixed extremes and partial alpha
    directed.push_back(load_row(126, 126, 32'h55aa01fe));
    directed.push_back(load_row(127, 126, 32'hff000080));
    directed.push_back(load_row(126, 127, 32'h00ff7f01));
    directed.push_back(load_row(127, 127, 32'h00000000));
    directed.push_back(query_row(63, 63, 1'b0, none));
    directed.push_back(load_row(127, 127, 32'hffffffff));
    directed.push_back(query_row(63, 63, 1'b0, none));
    directed.push_back(query_row(63, 64, 1'b1, outside));

    // Phases: identity, shrink, stretch, full-width and full-height boxes,
    // empty targets, saturating register values, then random small sizes
    phases[0] = '{sw: 8,   sh: 8,   tw: 8,    th: 8,    mode: IDLE_NONE};
    phases[1] = '{sw: 8,   sh: 8,   tw: 3,    th: 5,    mode: IDLE_SENDER};
    phases[2] = '{sw: 5,   sh: 7,   tw: 2047, th: 1024, mode: IDLE_RECEIVER};
    phases[3] = '{sw: 255, sh: 0,   tw: 1,    th: 1,    mode: IDLE_BOTH};
    phases[4] = '{sw: 1,   sh: 128, tw: 1,    th: 1,    mode: IDLE_NONE};
    phases[5] = '{sw: 16,  sh: 16,  tw: 0,    th: 7,    mode: IDLE_SENDER};
    phases[6] = '{sw: 128, sh: 2,   tw: 1024, th: 1,    mode: IDLE_RECEIVER};
    phases[7] = '{sw: 3,   sh: 3,   tw: 7,    th: 0,    mode: IDLE_BOTH};
    for (int unsigned p = 8; p < N_PHASES; p++)
      phases[p] = '{sw: $urandom_range(1, 16), sh: $urandom_range(1, 16),
                    tw: $urandom_range(1, 40), th: $urandom_range(1, 40),
                    mode: idle_e'(p % 4)};

    // Reset
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send_item(directed[i].it, directed[i].typed, directed[i].want,
                $urandom_range(0, 1));
    settle();

    foreach (phases[p]) run_phase(phases[p]);

    // Drain, then watch for stray results
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
